@@ rtl/vlsc_pkg.sv @@
// ----------------------------------------------------------------------------
// vlsc_pkg
// Types and constants shared by the versioned LRU slot cache.
// ----------------------------------------------------------------------------
package vlsc_pkg;

   localparam int CACHE_SLOTS = 48;
   localparam int IDX_W       = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
   localparam int KEY_W       = 64;
   localparam int VER_W       = 64;
   localparam int STAMP_W     = 32;
   localparam int FLAGS_W     = 3;
   localparam int SLOT_OUT_W  = 6;

   typedef struct packed {
      logic [KEY_W-1:0] req_key;
      logic [VER_W-1:0] req_version;
      logic             albedo_present;
      logic             normal_present;
      logic             rough_present;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic                  reload;
      logic                  evicted;
      logic [KEY_W-1:0]      evicted_key;
      logic                  albedo_flag;
      logic                  normal_flag;
      logic                  rough_flag;
   } rsp_type;

   // flags: bit 0 albedo, bit 1 normal, bit 2 roughness
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VER_W-1:0]   version;
      logic [STAMP_W-1:0] stamp;
      logic [FLAGS_W-1:0] flags;
   } slot_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

endpackage

@@ rtl/versioned_lru_slot_cache_unit.sv @@
// ----------------------------------------------------------------------------
// versioned_lru_slot_cache_unit
// Fully associative slot cache with version check and LRU replacement.
// ----------------------------------------------------------------------------
// Each accepted start runs a full scan of the slot RAM, then a write-back;
// busy stays high until the rsp_valid strobe cycle.
// A new lookup is taken only once the previous one is done; the linear
// scan reads one slot per cycle from the slot RAM.
// Reset: synchronous; clears valid bits, request tick and control state.
// Results are a one-cycle strobe; the receiver cannot stall.
module versioned_lru_slot_cache_unit
   import vlsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_SLOTS - 1);

   state_type state_ff, state_in;

   req_type            req_ff;
   logic [STAMP_W-1:0] tick_ff;
   logic [CACHE_SLOTS-1:0] valid_ff;

   // scan pipeline
   logic [IDX_W-1:0] rd_addr_ff;
   logic             issue_done_ff;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_idx_ff;

   // scan results
   logic               found_ff;
   logic [IDX_W-1:0]   found_idx_ff;
   logic [VER_W-1:0]   found_ver_ff;
   logic [FLAGS_W-1:0] found_flags_ff;
   logic               free_found_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic [STAMP_W-1:0] min_stamp_ff;
   logic [IDX_W-1:0]   victim_idx_ff;
   logic [KEY_W-1:0]   victim_key_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic           accept;
   logic           issuing;
   logic           scan_last;
   logic           ram_wr_en;
   logic [IDX_W-1:0] wr_idx;
   slot_entry_type wr_entry;
   slot_entry_type rd_entry;
   logic [FLAGS_W-1:0] req_flags;
   logic           ver_diff;
   rsp_type        rsp_next;

   assign accept    = start && (state_ff == ST_IDLE);
   assign issuing   = (state_ff == ST_SCAN) && !issue_done_ff;
   assign scan_last = chk_vld_ff && (chk_idx_ff == LAST_IDX);
   assign req_flags = {req_ff.rough_present, req_ff.normal_present, req_ff.albedo_present};
   assign ver_diff  = (found_ver_ff != req_ff.req_version);

   vlsc_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (CACHE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_en   (issuing),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_entry)
   );

   // FSM next state and write-back decision
   always_comb begin
      state_in  = state_ff;
      ram_wr_en = 1'b0;
      wr_idx    = found_idx_ff;
      wr_entry.key     = req_ff.req_key;
      wr_entry.version = req_ff.req_version;
      wr_entry.stamp   = tick_ff;
      wr_entry.flags   = req_flags;
      rsp_next.hit         = found_ff;
      rsp_next.slot_index  = SLOT_OUT_W'(found_idx_ff);
      rsp_next.reload      = 1'b1;
      rsp_next.evicted     = 1'b0;
      rsp_next.evicted_key = '0;
      rsp_next.albedo_flag = req_flags[0];
      rsp_next.normal_flag = req_flags[1];
      rsp_next.rough_flag  = req_flags[2];

      if (found_ff) begin
         // same version keeps the stored flags
         if (!ver_diff) begin
            wr_entry.flags = found_flags_ff;
         end
         rsp_next.reload = ver_diff;
      end else if (free_found_ff) begin
         wr_idx = free_idx_ff;
      end else begin
         wr_idx               = victim_idx_ff;
         rsp_next.evicted     = 1'b1;
         rsp_next.evicted_key = victim_key_ff;
      end
      rsp_next.slot_index  = SLOT_OUT_W'(wr_idx);
      rsp_next.albedo_flag = wr_entry.flags[0];
      rsp_next.normal_flag = wr_entry.flags[1];
      rsp_next.rough_flag  = wr_entry.flags[2];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         valid_ff      <= '0;
         issue_done_ff <= 1'b0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         chk_vld_ff   <= issuing;
         rsp_valid_ff <= ram_wr_en;
         if (accept) begin
            tick_ff       <= tick_ff + STAMP_W'(1);
            issue_done_ff <= 1'b0;
         end else if (issuing && (rd_addr_ff == LAST_IDX)) begin
            issue_done_ff <= 1'b1;
         end
         if (ram_wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // scan datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff        <= req_data;
         rd_addr_ff    <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (issuing) begin
            rd_addr_ff <= rd_addr_ff + IDX_W'(1);
         end
         if (chk_vld_ff) begin
            if (valid_ff[chk_idx_ff]) begin
               if (!found_ff && (rd_entry.key == req_ff.req_key)) begin
                  found_ff       <= 1'b1;
                  found_idx_ff   <= chk_idx_ff;
                  found_ver_ff   <= rd_entry.version;
                  found_flags_ff <= rd_entry.flags;
               end
            end else if (!free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= chk_idx_ff;
            end
            // victim only matters when every slot is valid; strict less
            // keeps the lowest slot among equal stamps
            if ((chk_idx_ff == '0) || (rd_entry.stamp < min_stamp_ff)) begin
               min_stamp_ff  <= rd_entry.stamp;
               victim_idx_ff <= chk_idx_ff;
               victim_key_ff <= rd_entry.key;
            end
         end
      end
      chk_idx_ff <= rd_addr_ff;
      if (ram_wr_en) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/vlsc_ram.sv @@
// ----------------------------------------------------------------------------
// vlsc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vlsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for versioned_lru_slot_cache_unit. A clocked driver
// issues lookups from a pending queue (random gaps, occasional pause until
// the pipeline is empty). A scoreboard model of the 48-slot LRU cache predicts
// every response, and a clocked monitor checks each strobed response field by
// field, in order.
// ----------------------------------------------------------------------------
module tb
   import vlsc_pkg::*;
();

   localparam int N_RANDOM   = 750;
   localparam int POOL_SIZE  = 64;
   localparam int HOT_SPAN   = 40;
   localparam int TAIL_WAIT  = 64;
   localparam int MAX_PRINTS = 40;

   typedef struct {
      req_type     req;
      int unsigned gap;
      bit          drain;
   } pend_item_type;

   logic    clock;
   logic    reset;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   pend_item_type pend_q[$];
   rsp_type       lookup_q[$];

   // cache model
   bit                 mdl_valid [CACHE_SLOTS];
   logic [KEY_W-1:0]   mdl_key   [CACHE_SLOTS];
   logic [VER_W-1:0]   mdl_ver   [CACHE_SLOTS];
   logic [STAMP_W-1:0] mdl_stamp [CACHE_SLOTS];
   logic [FLAGS_W-1:0] mdl_flags [CACHE_SLOTS];
   logic [STAMP_W-1:0] mdl_tick = '0;

   int n_issued  = 0;
   int n_done    = 0;
   int n_errors  = 0;
   int n_hits    = 0;
   int n_refresh = 0;
   int n_evicts  = 0;
   int n_pauses  = 0;

   versioned_lru_slot_cache_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d lookups issued, %0d responses seen", n_issued, n_done);
      $display("tb failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (n_errors < MAX_PRINTS)
         $display("%0t: response %0d, %s: got %h, expected %h", $realtime, n_done, what,
                  got, want);
      n_errors++;
   endtask

   // Model one lookup and queue the response it must produce.
   function automatic void cache_lookup(input req_type r);
      rsp_type            o;
      int                 hit_idx;
      int                 free_idx;
      int                 slot;
      logic [FLAGS_W-1:0] in_flags;
      hit_idx  = -1;
      free_idx = -1;
      o        = '0;
      mdl_tick = mdl_tick + STAMP_W'(1);
      in_flags = {r.rough_present, r.normal_present, r.albedo_present};
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         if (mdl_valid[i]) begin
            if (hit_idx < 0 && mdl_key[i] == r.req_key)
               hit_idx = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (hit_idx >= 0) begin
         slot = hit_idx;
         o.hit = 1'b1;
         n_hits++;
         mdl_stamp[slot] = mdl_tick;
         if (mdl_ver[slot] != r.req_version) begin
            mdl_ver[slot]   = r.req_version;
            mdl_flags[slot] = in_flags;
            o.reload        = 1'b1;
            n_refresh++;
         end
      end else begin
         if (free_idx >= 0) begin
            slot = free_idx;
         end else begin
            // oldest stamp wins, lowest slot on a tie
            slot = 0;
            for (int i = 1; i < CACHE_SLOTS; i++)
               if (mdl_stamp[i] < mdl_stamp[slot])
                  slot = i;
            o.evicted     = 1'b1;
            o.evicted_key = mdl_key[slot];
            n_evicts++;
         end
         mdl_valid[slot] = 1'b1;
         mdl_key[slot]   = r.req_key;
         mdl_ver[slot]   = r.req_version;
         mdl_stamp[slot] = mdl_tick;
         mdl_flags[slot] = in_flags;
         o.reload        = 1'b1;
      end
      o.slot_index  = SLOT_OUT_W'(slot);
      o.albedo_flag = mdl_flags[slot][0];
      o.normal_flag = mdl_flags[slot][1];
      o.rough_flag  = mdl_flags[slot][2];
      lookup_q.insert(lookup_q.size(), o);
   endfunction

   task automatic queue_lookup(input logic [KEY_W-1:0] key, input logic [VER_W-1:0] ver,
                               input logic [2:0] flags, input int unsigned gap,
                               input bit drain);
      pend_item_type it;
      it.req.req_key        = key;
      it.req.req_version    = ver;
      it.req.albedo_present = flags[0];
      it.req.normal_present = flags[1];
      it.req.rough_present  = flags[2];
      it.gap                = gap;
      it.drain              = drain;
      pend_q.insert(pend_q.size(), it);
   endtask

   // driver
   always @(posedge clock) begin : drv
      bit            take_next;
      bit            accepted;
      bit            in_flight;
      pend_item_type head;
      if (reset) begin
         start <= 1'b0;
      end else begin
         accepted  = start && !busy;
         take_next = accepted || !start;
         if (accepted) begin
            cache_lookup(req_data);
            n_issued <= n_issued + 1;
            void'(pend_q.pop_front());
         end
         in_flight = accepted || (n_issued != n_done);
         if (take_next) begin
            if (pend_q.size() == 0) begin
               start <= 1'b0;
            end else if (pend_q[0].gap > 0) begin
               head = pend_q[0];
               head.gap--;
               pend_q[0] = head;
               start <= 1'b0;
            end else if (pend_q[0].drain && in_flight) begin
               start <= 1'b0;
            end else begin
               if (pend_q[0].drain)
                  n_pauses++;
               start    <= 1'b1;
               req_data <= pend_q[0].req;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : mon
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid) begin
         got = rsp_data;
         if (lookup_q.size() == 0) begin
            report_mismatch("response with none outstanding, slot_index",
                            64'(got.slot_index), '0);
         end else begin
            want = lookup_q.pop_front();
            if (got.hit !== want.hit)
               report_mismatch("hit", 64'(got.hit), 64'(want.hit));
            if (got.slot_index !== want.slot_index)
               report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
            if (got.reload !== want.reload)
               report_mismatch("reload", 64'(got.reload), 64'(want.reload));
            if (got.evicted !== want.evicted)
               report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
            if (got.evicted_key !== want.evicted_key)
               report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
            if (got.albedo_flag !== want.albedo_flag)
               report_mismatch("albedo_flag", 64'(got.albedo_flag), 64'(want.albedo_flag));
            if (got.normal_flag !== want.normal_flag)
               report_mismatch("normal_flag", 64'(got.normal_flag), 64'(want.normal_flag));
            if (got.rough_flag !== want.rough_flag)
               report_mismatch("rough_flag", 64'(got.rough_flag), 64'(want.rough_flag));
         end
         n_done <= n_done + 1;
      end
   end

   // stimulus
   initial begin : stim
      logic [KEY_W-1:0] pool_key [POOL_SIZE];
      logic [VER_W-1:0] pool_ver [POOL_SIZE];
      logic [KEY_W-1:0] key;
      logic [VER_W-1:0] ver;
      int               base;
      int               p;
      int               sel;
      int               vsel;
      bit               quiet;
      quiet = 1'b0;
      base  = 0;

      // directed: field extremes, same-version hit, version change
      queue_lookup('0, '0, 3'b000, 0, 1'b0);
      queue_lookup('1, '1, 3'b111, 0, 1'b0);
      queue_lookup('0, '0, 3'b111, 3, 1'b0);
      queue_lookup('0, 64'h1, 3'b101, 0, 1'b0);
      queue_lookup('1, '0, 3'b010, 16, 1'b0);
      queue_lookup(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 3'b011, 0, 1'b0);
      queue_lookup(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 3'b110, 0, 1'b1);
      queue_lookup('1, '0, 3'b001, 0, 1'b0);
      queue_lookup(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 3'b100, 1, 1'b0);
      queue_lookup(64'h7fff_ffff_ffff_ffff, '1, 3'b001, 0, 1'b0);
      queue_lookup(64'h5555_5555_aaaa_aaaa, 64'haaaa_aaaa_5555_5555, 3'b000, 0, 1'b0);

      // key pool: larger than the cache so a moving hot window causes
      // hits, version refreshes and LRU evictions
      foreach (pool_key[i]) begin
         pool_key[i] = {$urandom, $urandom};
         pool_ver[i] = {$urandom, $urandom};
      end
      pool_key[0] = '0;
      pool_key[1] = '1;

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 50 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         if (n % 100 == 99)
            base = (base + $urandom_range(8, 24)) % POOL_SIZE;
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            key = {$urandom, $urandom};
            ver = {$urandom, $urandom};
         end else begin
            if (sel < 85)
               p = (base + $urandom_range(0, HOT_SPAN - 1)) % POOL_SIZE;
            else
               p = $urandom_range(0, POOL_SIZE - 1);
            vsel = $urandom_range(0, 9);
            if (vsel < 5)
               ver = pool_ver[p];
            else if (vsel < 8)
               ver = pool_ver[p] + VER_W'(1);
            else
               ver = {$urandom, $urandom};
            pool_ver[p] = ver;
            key = pool_key[p];
         end
         queue_lookup(key, ver, 3'($urandom_range(0, 7)),
                      quiet ? 0 : $urandom_range(0, 16), (n % 150 == 75));
      end

      @(negedge reset);
      while (pend_q.size() != 0 || start)
         @(posedge clock);
      while (n_done != n_issued)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (lookup_q.size() != 0)
         report_mismatch("responses never seen", 64'(lookup_q.size()), '0);

      $display("run: %0d lookups, %0d hits (%0d with version refresh), %0d evictions",
               n_issued, n_hits, n_refresh, n_evicts);
      $display("run: %0d pauses until idle, %0d mismatches", n_pauses, n_errors);
      if (n_errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
